// ----- design/edge_nonmax_suppression_top_assert.svh -----
// Assertion macros for the edge non-maximum suppression block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef EDGE_NONMAX_SUPPRESSION_TOP_ASSERT_SVH
`define EDGE_NONMAX_SUPPRESSION_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ENMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ENMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/enms_pkg.sv -----
// Package for the edge non-maximum suppression block: sizes, codes, queue entry type
// and the register clamp functions. No dependencies.
package enms_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int MAG_W     = 8;
    localparam int DIR_W     = 2;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WCNT_W = COL_W + 1;
    localparam int HCNT_W = ROW_W + 1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1
    } t_reg_idx;

    typedef enum logic [DIR_W-1:0] {
        DIR_HORZ = 2'd0,
        DIR_D45  = 2'd1,
        DIR_VERT = 2'd2,
        DIR_D135 = 2'd3
    } t_dir;

    // One queue entry: a pixel column for the window, or a drain beat.
    typedef struct packed {
        logic             pixel;
        logic             emit;
        logic [MAG_W-1:0] top;
        logic [MAG_W-1:0] mid;
        logic [MAG_W-1:0] bot;
        logic [DIR_W-1:0] dir;
    } t_work;

    function automatic logic [WCNT_W-1:0] eff_width(input logic [CFG_W-1:0] v);
        if (v == '0) return WCNT_W'(1);
        if (int'(v) > MAX_WIDTH) return WCNT_W'(MAX_WIDTH);
        return WCNT_W'(v);
    endfunction

    function automatic logic [HCNT_W-1:0] eff_height(input logic [CFG_W-1:0] v);
        if (v == '0) return HCNT_W'(1);
        if (int'(v) > MAX_HEIGHT) return HCNT_W'(MAX_HEIGHT);
        return HCNT_W'(v);
    endfunction

endpackage

// ----- design/enms_front.sv -----
// Front end: accepts beats, tracks input position and pending count, owns the line buffers.
// Depends on enms_pkg.
module enms_front import enms_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_command,
    input  logic [MAG_W-1:0]  i_magnitude,
    input  logic [DIR_W-1:0]  i_direction,
    input  logic [WCNT_W-1:0] i_width,
    input  logic [HCNT_W-1:0] i_height,
    input  logic              i_q_full,
    output logic              o_work_valid,
    output t_work             o_work
);

    logic [MAG_W-1:0] r_bank0 [MAX_WIDTH];
    logic [MAG_W-1:0] r_bank1 [MAX_WIDTH];
    logic [DIR_W-1:0] r_dirs  [MAX_WIDTH];

    logic [MAG_W-1:0] r_rd0, r_rd1;
    logic [DIR_W-1:0] r_rd_dir;

    logic [COL_W-1:0]  r_in_col, n_in_col;
    logic [ROW_W-1:0]  r_in_row, n_in_row;
    logic [WCNT_W-1:0] r_pend, n_pend;

    logic             r_s1_v, n_s1_v;
    logic             r_s1_pix, r_s1_emit, r_s1_par;
    logic [MAG_W-1:0] r_s1_mag;

    logic acc, acc_pix, acc_drn, emit_pix;
    logic [WCNT_W-1:0] col_inc;
    logic [HCNT_W-1:0] row_inc;

    assign o_ready = !r_s1_v || !i_q_full;
    assign acc     = i_valid && o_ready;
    assign acc_pix = acc && (i_command == CMD_PIXEL);
    assign acc_drn = acc && (i_command == CMD_DRAIN) && (r_pend != '0);

    // a pixel emits only once the pipeline holds W+1 pending outputs
    assign emit_pix = ({1'b0, r_pend} >= ({1'b0, i_width} + (WCNT_W + 1)'(1)));

    assign col_inc = WCNT_W'(r_in_col) + WCNT_W'(1);
    assign row_inc = HCNT_W'(r_in_row) + HCNT_W'(1);

    always_comb begin
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        n_pend   = r_pend;
        if (acc_pix) begin
            if (col_inc >= i_width) begin
                n_in_col = '0;
                n_in_row = (row_inc >= i_height) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                n_in_col = col_inc[COL_W-1:0];
            end
            if (!emit_pix) n_pend = r_pend + WCNT_W'(1);
        end else if (acc_drn) begin
            n_pend = r_pend - WCNT_W'(1);
        end
        // drop a drain with nothing pending; otherwise hold until the queue takes it
        if (acc) n_s1_v = acc_pix || acc_drn;
        else if (r_s1_v && !i_q_full) n_s1_v = 1'b0;
        else n_s1_v = r_s1_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_pend   <= '0;
            r_s1_v   <= 1'b0;
        end else begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
            r_pend   <= n_pend;
            r_s1_v   <= n_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pix  <= acc_pix;
            r_s1_emit <= acc_pix ? emit_pix : 1'b1;
            r_s1_par  <= r_in_row[0];
            r_s1_mag  <= i_magnitude;
        end
    end

    // read-first line buffers: reads return the old entries, written by the two rows before
    always_ff @(posedge i_clk) begin
        if (acc_pix) begin
            if (!r_in_row[0]) r_bank0[r_in_col] <= i_magnitude;
            else r_bank1[r_in_col] <= i_magnitude;
            r_dirs[r_in_col] <= i_direction;
            r_rd0    <= r_bank0[r_in_col];
            r_rd1    <= r_bank1[r_in_col];
            r_rd_dir <= r_dirs[r_in_col];
        end
    end

    assign o_work_valid = r_s1_v;
    assign o_work.pixel = r_s1_pix;
    assign o_work.emit  = r_s1_emit;
    assign o_work.top   = r_s1_par ? r_rd1 : r_rd0;
    assign o_work.mid   = r_s1_par ? r_rd0 : r_rd1;
    assign o_work.bot   = r_s1_mag;
    assign o_work.dir   = r_rd_dir;

endmodule

// ----- design/enms_queue.sv -----
// Short FIFO of work entries between the front and back ends.
// Depends on enms_pkg.
module enms_queue import enms_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_data,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_work o_data
);

    t_work r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;

    logic do_push, do_pop;

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            if (do_pop) r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            r_cnt <= r_cnt + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

endmodule

// ----- design/enms_back.sv -----
// Back end: 3x3 window, suppression compare, output position and output register.
// Depends on enms_pkg and edge_nonmax_suppression_top_assert.svh.
`include "edge_nonmax_suppression_top_assert.svh"
module enms_back import enms_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_work             i_work,
    output logic              o_pop,
    input  logic [WCNT_W-1:0] i_width,
    input  logic [HCNT_W-1:0] i_height,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [MAG_W-1:0]  o_nms_value,
    output logic              o_frame_last
);

    logic [2:0][2:0][MAG_W-1:0] r_win, n_win;
    logic [DIR_W-1:0] r_cdir;
    logic [COL_W-1:0] r_out_col;
    logic [ROW_W-1:0] r_out_row;
    logic             r_o_valid, r_o_last;
    logic [MAG_W-1:0] r_o_nms;

    logic pop_pix, load, last, border;
    logic [WCNT_W-1:0] col_inc;
    logic [HCNT_W-1:0] row_inc;
    logic [MAG_W-1:0]  nb_a, nb_b, supp, value;

    assign o_pop   = i_valid && (!i_work.emit || !r_o_valid || i_ready);
    assign pop_pix = o_pop && i_work.pixel;
    assign load    = o_pop && i_work.emit;

    // shift left, load the new right column
    always_comb begin
        n_win = r_win;
        if (pop_pix) begin
            for (int r = 0; r < 3; r++) begin
                n_win[r][0] = r_win[r][1];
                n_win[r][1] = r_win[r][2];
            end
            n_win[0][2] = i_work.top;
            n_win[1][2] = i_work.mid;
            n_win[2][2] = i_work.bot;
        end
    end

    assign col_inc = WCNT_W'(r_out_col) + WCNT_W'(1);
    assign row_inc = HCNT_W'(r_out_row) + HCNT_W'(1);
    assign last    = (col_inc >= i_width) && (row_inc >= i_height);
    assign border  = (r_out_col == '0) || (r_out_row == '0) ||
                     (col_inc >= i_width) || (row_inc >= i_height);

    always_comb begin
        case (t_dir'(r_cdir))
            DIR_HORZ: begin nb_a = n_win[1][0]; nb_b = n_win[1][2]; end
            DIR_D45:  begin nb_a = n_win[0][2]; nb_b = n_win[2][0]; end
            DIR_VERT: begin nb_a = n_win[0][1]; nb_b = n_win[2][1]; end
            default:  begin nb_a = n_win[0][0]; nb_b = n_win[2][2]; end
        endcase
        supp  = (n_win[1][1] >= nb_a && n_win[1][1] >= nb_b) ? n_win[1][1] : '0;
        value = (i_work.pixel && !border) ? supp : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= '0;
            r_cdir    <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_win <= n_win;
            if (pop_pix) r_cdir <= i_work.dir;
            if (load) begin
                r_o_valid <= 1'b1;
                if (last) begin
                    r_out_col <= '0;
                    r_out_row <= '0;
                end else if (col_inc >= i_width) begin
                    r_out_col <= '0;
                    r_out_row <= (row_inc >= i_height) ? '0 : row_inc[ROW_W-1:0];
                end else begin
                    r_out_col <= col_inc[COL_W-1:0];
                end
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_nms  <= value;
            r_o_last <= last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_nms_value  = r_o_nms;
    assign o_frame_last = r_o_last;

    `ENMS_ASSERT_NEXT(a_last_rewinds, i_clk, i_rst_n, load && last,
        r_out_col == '0 && r_out_row == '0, "output position not rewound after frame end")
    `ENMS_ASSERT_NEXT(a_border_zero, i_clk, i_rst_n, load && border,
        r_o_nms == '0, "border output is not zero")
    `ENMS_ASSERT_NEXT(a_drain_keeps_win, i_clk, i_rst_n, o_pop && !i_work.pixel,
        $stable(r_win[1][1]) && $stable(r_cdir), "drain beat moved the window")

endmodule

// ----- design/edge_nonmax_suppression_top.sv -----
// Top level of the edge non-maximum suppression block: configuration registers and
// the front end, work queue and back end. Depends on enms_pkg and the enms_* modules.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_command, i_magnitude, i_direction
//  out     | output    | o_out_valid / i_out_ready  | o_nms_value, o_frame_last
//  cfg     | input     | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
//  One beat per clock is taken while o_in_ready is high; the line buffer read is
//  registered together with the accepted beat.
//  Reset is synchronous and active low; the line buffers are not cleared.
//  The back end stalls only on the output register; the four-entry queue absorbs
//  that stall, so o_in_ready drops only after the queue and front register fill up.
module edge_nonmax_suppression_top import enms_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_command,
    input  logic [MAG_W-1:0]     i_magnitude,
    input  logic [DIR_W-1:0]     i_direction,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [MAG_W-1:0]     o_nms_value,
    output logic                 o_frame_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]  r_width, r_height;
    logic [WCNT_W-1:0] width_eff;
    logic [HCNT_W-1:0] height_eff;

    logic  q_full, q_valid, q_pop, work_valid;
    t_work work_in, work_out;

    // Hold the raw register values; clamp to the supported frame size on use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_WIDTH) r_width <= i_cfg_data;
            else if (i_cfg_index == REG_HEIGHT) r_height <= i_cfg_data;
        end
    end

    assign width_eff  = eff_width(r_width);
    assign height_eff = eff_height(r_height);

    // Accept and classify beats, read and update the line buffers.
    enms_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_command    (i_command),
        .i_magnitude  (i_magnitude),
        .i_direction  (i_direction),
        .i_width      (width_eff),
        .i_height     (height_eff),
        .i_q_full     (q_full),
        .o_work_valid (work_valid),
        .o_work       (work_in)
    );

    // Decouple the two halves so each can stall on its own.
    enms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (work_valid),
        .i_data  (work_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (work_out)
    );

    // Advance the window, compare along the direction, drive the output register.
    enms_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_work       (work_out),
        .o_pop        (q_pop),
        .i_width      (width_eff),
        .i_height     (height_eff),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_nms_value  (o_nms_value),
        .o_frame_last (o_frame_last)
    );

endmodule
